// ===== src/rlti_pkg.sv =====
// Package for the radix literal to integer parser.
// Holds character codes, lane indexes, the prefix type and the accumulator state type.
// Depends on nothing; used by rlti_feed and radix_literal_to_integer_top.
package rlti_pkg;

   localparam int unsigned NUM_LANES = 4;
   localparam int unsigned ACC_W     = 64;
   localparam int unsigned CHAR_W    = 8;

   // Lane order: hex, decimal, octal, binary.
   localparam logic [1:0] LANE_HEX = 2'd0;
   localparam logic [1:0] LANE_DEC = 2'd1;
   localparam logic [1:0] LANE_OCT = 2'd2;
   localparam logic [1:0] LANE_BIN = 2'd3;

   localparam logic [4:0] LANE_RADIX [NUM_LANES] = '{5'd16, 5'd10, 5'd8, 5'd2};

   localparam logic [CHAR_W-1:0] CH_DOLLAR  = 8'h24;
   localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOWER_B = 8'h62;
   localparam logic [CHAR_W-1:0] CH_LOWER_H = 8'h68;
   localparam logic [CHAR_W-1:0] CH_LOWER_O = 8'h6F;
   localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
   localparam logic [CHAR_W-1:0] CASE_DELTA = 8'h20;
   localparam logic [CHAR_W-1:0] ALPHA_BIAS = 8'd87;  // 'a' - 10

   typedef enum logic [1:0] {
      PREFIX_NONE = 2'd0,
      PREFIX_HEX  = 2'd1,
      PREFIX_OCT  = 2'd2
   } prefix_type;

   typedef logic [ACC_W-1:0] acc_array_type [NUM_LANES];

   // Running accumulators with one sticky digit-error bit per lane.
   typedef struct {
      acc_array_type          acc;
      logic [NUM_LANES-1:0]   err;
   } lanes_type;

   function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] c);
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         return c + CASE_DELTA;
      end
      return c;
   endfunction

endpackage

// ===== src/rlti_feed.sv =====
// Digit feed for the radix literal parser: folds one character into all four lanes.
// Depends on rlti_pkg.
module rlti_feed (
   input  logic [7:0]          char_code,
   input  rlti_pkg::lanes_type lanes_cur,
   output rlti_pkg::lanes_type lanes_next
);

   logic [7:0] lower_c;
   logic [7:0] digit;
   logic       below_zero;

   always_comb begin
      lower_c    = rlti_pkg::to_lower(char_code);
      below_zero = 1'b0;
      if (lower_c >= rlti_pkg::CH_LOWER_A) begin
         digit = lower_c - rlti_pkg::ALPHA_BIAS;
      end else begin
         digit      = lower_c - rlti_pkg::CH_ZERO;
         // Codes below '0' wrap to a huge value, invalid in every radix.
         below_zero = (lower_c < rlti_pkg::CH_ZERO);
      end
   end

   always_comb begin
      for (int i = 0; i < rlti_pkg::NUM_LANES; i++) begin
         if (below_zero || digit >= {3'b000, rlti_pkg::LANE_RADIX[i]}) begin
            lanes_next.acc[i] = lanes_cur.acc[i];
            lanes_next.err[i] = 1'b1;
         end else begin
            lanes_next.acc[i] = lanes_cur.acc[i] * 64'(rlti_pkg::LANE_RADIX[i])
                              + 64'(digit);
            lanes_next.err[i] = lanes_cur.err[i];
         end
      end
   end

endmodule

// ===== src/radix_literal_to_integer_top.sv =====
// Radix literal to integer parser, top level.
// Path: one input register, one multiply-add by a constant radix per lane, and the result
// register, which drives rsp_valid. Throughput: one character per cycle, except that a last
// character stalls while the result register is full and not being read.
// Reset: synchronous, active high; clears all literal state and drops both valid flags.
module radix_literal_to_integer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_value,
   output logic        rsp_ok
);

   // Input register stage. Each transfer on the request side lands here first.
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_char_ff;
   logic       s1_last_ff;
   logic       s1_go;

   // Literal state. Each non-last character is folded into the lanes as it leaves the
   // input register, as its flag shows it is not a suffix; the last character itself
   // is folded only when it turns out to be a digit.
   logic [1:0]           pos_ff, pos_in;
   logic [7:0]           first_ff, first_in;
   rlti_pkg::prefix_type prefix_ff, prefix_in;
   rlti_pkg::lanes_type  lanes_ff, lanes_in;

   // Result register. It decouples the two channels, so a waiting result does not
   // stall the next characters unless they also end a literal.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_value_ff, rsp_value_in;
   logic        rsp_ok_ff, rsp_ok_in;

   rlti_pkg::prefix_type new_prefix;
   logic [7:0]           lower_c;
   logic [7:0]           feed_char;
   rlti_pkg::lanes_type  lanes_fed;
   logic [1:0]           sel;
   logic                 use_fed;
   logic [63:0]          sel_acc;
   logic                 sel_err;

   // A non-last character never produces a result, so it moves on freely. A last
   // character needs the result register to be empty or emptying.
   assign s1_go     = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_go;

   assign s1_valid_in = (req_valid && req_ready) ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_char_ff <= req_char_code;
         s1_last_ff <= req_is_last;
      end
   end

   // Prefix detection: a leading '$', or '0' followed by 'x' or 'o' in either case.
   always_comb begin
      lower_c    = rlti_pkg::to_lower(s1_char_ff);
      new_prefix = rlti_pkg::PREFIX_NONE;
      if (pos_ff == 2'd0 && s1_char_ff == rlti_pkg::CH_DOLLAR) begin
         new_prefix = rlti_pkg::PREFIX_HEX;
      end else if (pos_ff == 2'd1 && first_ff == rlti_pkg::CH_ZERO
                   && lower_c == rlti_pkg::CH_LOWER_X) begin
         new_prefix = rlti_pkg::PREFIX_HEX;
      end else if (pos_ff == 2'd1 && first_ff == rlti_pkg::CH_ZERO
                   && lower_c == rlti_pkg::CH_LOWER_O) begin
         new_prefix = rlti_pkg::PREFIX_OCT;
      end
      // A prefix character is held as a zero digit, which leaves every lane unchanged.
      feed_char = (new_prefix != rlti_pkg::PREFIX_NONE) ? rlti_pkg::CH_ZERO : s1_char_ff;
   end

   rlti_feed u_feed (
      .char_code  (feed_char),
      .lanes_cur  (lanes_ff),
      .lanes_next (lanes_fed)
   );

   // Radix choice on the last character. Without a prefix, a final lowercase
   // 'h', 'b' or 'o' is a suffix and is not folded in.
   always_comb begin
      sel     = rlti_pkg::LANE_DEC;
      use_fed = 1'b0;
      if (new_prefix != rlti_pkg::PREFIX_NONE) begin
         sel = (new_prefix == rlti_pkg::PREFIX_HEX) ? rlti_pkg::LANE_HEX : rlti_pkg::LANE_OCT;
      end else if (prefix_ff != rlti_pkg::PREFIX_NONE) begin
         use_fed = 1'b1;
         sel = (prefix_ff == rlti_pkg::PREFIX_HEX) ? rlti_pkg::LANE_HEX : rlti_pkg::LANE_OCT;
      end else if (s1_char_ff == rlti_pkg::CH_LOWER_H) begin
         sel = rlti_pkg::LANE_HEX;
      end else if (s1_char_ff == rlti_pkg::CH_LOWER_B) begin
         sel = rlti_pkg::LANE_BIN;
      end else if (s1_char_ff == rlti_pkg::CH_LOWER_O) begin
         sel = rlti_pkg::LANE_OCT;
      end else begin
         use_fed = 1'b1;
         sel     = rlti_pkg::LANE_DEC;
      end
      sel_acc = use_fed ? lanes_fed.acc[sel] : lanes_ff.acc[sel];
      sel_err = use_fed ? lanes_fed.err[sel] : lanes_ff.err[sel];
   end

   // Next literal state. After a last character everything returns to its reset value.
   always_comb begin
      pos_in    = pos_ff;
      first_in  = first_ff;
      prefix_in = prefix_ff;
      lanes_in  = lanes_ff;
      if (s1_go) begin
         if (s1_last_ff) begin
            pos_in       = 2'd0;
            first_in     = '0;
            prefix_in    = rlti_pkg::PREFIX_NONE;
            lanes_in.err = '0;
            for (int i = 0; i < rlti_pkg::NUM_LANES; i++) begin
               lanes_in.acc[i] = '0;
            end
         end else begin
            lanes_in = lanes_fed;
            if (pos_ff == 2'd0) begin
               first_in = s1_char_ff;
            end
            if (new_prefix != rlti_pkg::PREFIX_NONE) begin
               prefix_in = new_prefix;
            end
            if (pos_ff != 2'd2) begin
               pos_in = pos_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 2'd0;
         first_ff     <= '0;
         prefix_ff    <= rlti_pkg::PREFIX_NONE;
         lanes_ff.err <= '0;
         for (int i = 0; i < rlti_pkg::NUM_LANES; i++) begin
            lanes_ff.acc[i] <= '0;
         end
      end else begin
         pos_ff    <= pos_in;
         first_ff  <= first_in;
         prefix_ff <= prefix_in;
         lanes_ff  <= lanes_in;
      end
   end

   // Result register. An invalid literal reports a value of zero.
   always_comb begin
      rsp_value_in = rsp_value_ff;
      rsp_ok_in    = rsp_ok_ff;
      if (s1_go && s1_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = sel_err ? '0 : sel_acc;
         rsp_ok_in    = !sel_err;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_ok_ff    <= rsp_ok_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_ok    = rsp_ok_ff;

endmodule

// ===== src/rlti_checker.sv =====
// Port-level checker for radix_literal_to_integer_top, with its bind statement.
// Depends on the top level's port list only.
module rlti_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_char_code,
   input logic        req_is_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_value,
   input logic        rsp_ok
);

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_ok))
      else $error("rsp payload changed while stalled");

   // An invalid literal always reports zero.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_value == 64'd0)
      else $error("invalid literal with nonzero value");

   // With the result register empty, the input side is never stalled.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled with empty result register");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set right after reset");

   // A stalled character holds its payload until its transfer.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_char_code)
                                  && $stable(req_is_last))
      else $error("req payload changed while stalled");

endmodule

bind radix_literal_to_integer_top rlti_checker u_rlti_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_char_code (req_char_code),
   .req_is_last   (req_is_last),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_value     (rsp_value),
   .rsp_ok        (rsp_ok)
);

// ===== tb/sv/tb_radix_literal_to_integer_top.sv =====
// Self-checking testbench for radix_literal_to_integer_top.
// Streams numeric literals one character per transfer and checks every converted value.
// Depends on rlti_pkg and the radix_literal_to_integer_top RTL.
`timescale 1ns / 1ps

module tb_radix_literal_to_integer_top;

   // The receiver hold-off, in cycles, for the stretch that backs up the block.
   localparam int unsigned HOLD_CYCLES = 300;
   // Cycles without any transfer on either channel before the run is declared hung.
   localparam int unsigned IDLE_LIMIT  = 2000;
   // Random stimulus stops once about this many characters are queued.
   localparam int unsigned RANDOM_CHARS = 650;

   // Shapes of random literals.
   typedef enum int unsigned {
      LIT_DOLLAR_HEX,
      LIT_ZERO_X_HEX,
      LIT_ZERO_O_OCT,
      LIT_DECIMAL,
      LIT_SUFFIX,
      LIT_SHORT,
      LIT_NOISE,
      LIT_BROKEN
   } lit_kind_type;

   // One character on its way to the block, with flags that steer the two drivers.
   typedef struct packed {
      logic [7:0] code;
      logic       last;
      logic       drain;     // wait until every converted literal has been returned
      logic       hold_rx;   // start the long receiver hold-off with this character
   } char_item_type;

   typedef struct packed {
      logic [63:0] value;
      logic        ok;
   } literal_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_code = 8'h00;
   logic        req_is_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_value;
   logic        rsp_ok;

   radix_literal_to_integer_top uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_is_last   (req_is_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value     (rsp_value),
      .rsp_ok        (rsp_ok)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   char_item_type      char_stream[$];
   literal_result_type converted_literals[$];
   logic [7:0]         lit_buf[$];

   int unsigned error_count = 0;
   int unsigned idle_cycles = 0;

   // Handshake flags captured at the rising edge and read by the drivers at the falling edge.
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;

   // Driver-side pacing state.
   int unsigned tx_gap = 0;
   int unsigned tx_loaded = 0;
   logic        tx_burst = 1'b0;
   logic        rx_hold_req = 1'b0;

   // Receiver-side pacing state.
   int unsigned rx_wait = 0;
   int unsigned rx_hold = 0;
   int unsigned rx_count = 0;
   logic        rx_burst = 1'b0;

   // ------------------------------------------------------------------------
   // Literal converter. This model delays every character by one transfer so
   // that the final one can still be read as a radix suffix; its state is
   // a position counter, the first character, the prefix seen so far, the
   // held character, and one accumulator with an error bit for each of the
   // four radixes.
   // ------------------------------------------------------------------------
   logic [1:0]           pos_cnt;
   logic [7:0]           first_ch;
   rlti_pkg::prefix_type seen_prefix;
   logic [7:0]           held_ch;
   logic [63:0]          lane_acc [4];
   logic [3:0]           lane_err;

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      if (c >= rlti_pkg::CH_UPPER_A && c <= rlti_pkg::CH_UPPER_Z) begin
         return c + rlti_pkg::CASE_DELTA;
      end
      return c;
   endfunction

   function automatic logic [63:0] lane_base(input int lane);
      case (lane)
         rlti_pkg::LANE_HEX: return 64'd16;
         rlti_pkg::LANE_DEC: return 64'd10;
         rlti_pkg::LANE_OCT: return 64'd8;
         default:            return 64'd2;
      endcase
   endfunction

   task automatic clear_literal();
      pos_cnt     = 2'd0;
      first_ch    = 8'h00;
      seen_prefix = rlti_pkg::PREFIX_NONE;
      held_ch     = 8'h00;
      lane_err    = 4'b0000;
      for (int i = 0; i < 4; i++) begin
         lane_acc[i] = 64'd0;
      end
   endtask

   // Feeds one digit to all four lanes at once. The digit value wraps as a
   // 32-bit unsigned number, so anything below '0' counts as a huge value.
   task automatic take_digit(input logic [7:0] c);
      int unsigned v;
      int unsigned d;
      v = 32'(fold_case(c));
      if (v >= rlti_pkg::CH_LOWER_A) begin
         d = v - rlti_pkg::CH_LOWER_A + 10;
      end else begin
         d = v - rlti_pkg::CH_ZERO;
      end
      for (int i = 0; i < 4; i++) begin
         if (64'(d) >= lane_base(i)) begin
            lane_err[i] = 1'b1;
         end else begin
            lane_acc[i] = lane_acc[i] * lane_base(i) + 64'(d);
         end
      end
   endtask

   task automatic convert_char(input logic [7:0] c, input logic last);
      logic [7:0]           lc;
      rlti_pkg::prefix_type new_prefix;
      logic [1:0]           sel;
      literal_result_type   res;
      lc = fold_case(c);
      new_prefix = rlti_pkg::PREFIX_NONE;
      if (pos_cnt == 2'd0 && c == rlti_pkg::CH_DOLLAR) begin
         new_prefix = rlti_pkg::PREFIX_HEX;
      end else if (pos_cnt == 2'd1 && first_ch == rlti_pkg::CH_ZERO
                   && lc == rlti_pkg::CH_LOWER_X) begin
         new_prefix = rlti_pkg::PREFIX_HEX;
      end else if (pos_cnt == 2'd1 && first_ch == rlti_pkg::CH_ZERO
                   && lc == rlti_pkg::CH_LOWER_O) begin
         new_prefix = rlti_pkg::PREFIX_OCT;
      end
      if (pos_cnt != 2'd0) begin
         take_digit(held_ch);
      end
      if (!last) begin
         // A prefix letter is held as a zero digit, which leaves the value alone.
         held_ch = (new_prefix != rlti_pkg::PREFIX_NONE) ? rlti_pkg::CH_ZERO : c;
         if (pos_cnt == 2'd0) begin
            first_ch = c;
         end
         if (new_prefix != rlti_pkg::PREFIX_NONE) begin
            seen_prefix = new_prefix;
         end
         if (pos_cnt != 2'd2) begin
            pos_cnt = pos_cnt + 2'd1;
         end
      end else begin
         if (new_prefix != rlti_pkg::PREFIX_NONE) begin
            // The literal ends on its prefix, so the digit run is empty.
            sel = (new_prefix == rlti_pkg::PREFIX_HEX) ? rlti_pkg::LANE_HEX
                                                       : rlti_pkg::LANE_OCT;
         end else if (seen_prefix != rlti_pkg::PREFIX_NONE) begin
            // With a prefix the final letter is an ordinary digit.
            take_digit(c);
            sel = (seen_prefix == rlti_pkg::PREFIX_HEX) ? rlti_pkg::LANE_HEX
                                                        : rlti_pkg::LANE_OCT;
         end else if (c == rlti_pkg::CH_LOWER_H) begin
            sel = rlti_pkg::LANE_HEX;
         end else if (c == rlti_pkg::CH_LOWER_B) begin
            sel = rlti_pkg::LANE_BIN;
         end else if (c == rlti_pkg::CH_LOWER_O) begin
            sel = rlti_pkg::LANE_OCT;
         end else begin
            take_digit(c);
            sel = rlti_pkg::LANE_DEC;
         end
         // An invalid literal reports a value of zero.
         res.ok    = !lane_err[sel];
         res.value = lane_err[sel] ? 64'd0 : lane_acc[sel];
         converted_literals.push_back(res);
         clear_literal();
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------------
   function automatic int unsigned draw_gap(input logic burst);
      if (burst) begin
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   task automatic push_char(input logic [7:0] c, input logic last, input logic drain,
                            input logic hold);
      char_item_type it;
      it.code    = c;
      it.last    = last;
      it.drain   = drain;
      it.hold_rx = hold;
      char_stream.push_back(it);
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         push_char(s[i], i == s.len() - 1, 1'b0, 1'b0);
      end
   endtask

   // Moves the scratch literal into the stream; the flags go on its first character.
   task automatic flush_literal(input logic drain, input logic hold);
      int n;
      n = lit_buf.size();
      for (int i = 0; i < n; i++) begin
         push_char(lit_buf[i], i == n - 1, drain && i == 0, hold && i == 0);
      end
      lit_buf.delete();
   endtask

   // A random digit below the given radix; letters come in either case.
   function automatic logic [7:0] digit_char(input int unsigned base);
      int unsigned d;
      logic [7:0]  c;
      d = $urandom_range(0, base - 1);
      if (d < 10) begin
         c = rlti_pkg::CH_ZERO + d[7:0];
      end else begin
         c = rlti_pkg::CH_LOWER_A + d[7:0] - 8'd10;
         if ($urandom_range(0, 1) == 1) begin
            c = c - rlti_pkg::CASE_DELTA;
         end
      end
      return c;
   endfunction

   task automatic add_digits(input int unsigned base, input int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
         lit_buf.push_back(digit_char(base));
      end
   endtask

   // Mostly short digit runs; now and then long enough to wrap past 64 bits.
   function automatic int unsigned digit_count();
      if ($urandom_range(0, 7) == 0) begin
         return $urandom_range(15, 22);
      end
      return $urandom_range(0, 6);
   endfunction

   task automatic build_random_literal();
      lit_kind_type kind;
      int unsigned  n;
      int unsigned  k;
      kind = lit_kind_type'($urandom_range(0, 7));
      case (kind)
         LIT_DOLLAR_HEX: begin
            lit_buf.push_back(rlti_pkg::CH_DOLLAR);
            add_digits(16, digit_count());
         end
         LIT_ZERO_X_HEX: begin
            lit_buf.push_back(rlti_pkg::CH_ZERO);
            lit_buf.push_back($urandom_range(0, 1) ? rlti_pkg::CH_LOWER_X
                              : rlti_pkg::CH_LOWER_X - rlti_pkg::CASE_DELTA);
            add_digits(16, digit_count());
         end
         LIT_ZERO_O_OCT: begin
            lit_buf.push_back(rlti_pkg::CH_ZERO);
            lit_buf.push_back($urandom_range(0, 1) ? rlti_pkg::CH_LOWER_O
                              : rlti_pkg::CH_LOWER_O - rlti_pkg::CASE_DELTA);
            add_digits(8, digit_count());
         end
         LIT_DECIMAL: begin
            add_digits(10, digit_count() + 1);
         end
         LIT_SUFFIX: begin
            k = $urandom_range(0, 2);
            if (k == 0) begin
               add_digits(16, digit_count());
               lit_buf.push_back(rlti_pkg::CH_LOWER_H);
            end else if (k == 1) begin
               add_digits(2, digit_count() * 3);
               lit_buf.push_back(rlti_pkg::CH_LOWER_B);
            end else begin
               add_digits(8, digit_count());
               lit_buf.push_back(rlti_pkg::CH_LOWER_O);
            end
         end
         LIT_SHORT: begin
            add_digits(16, $urandom_range(1, 2));
         end
         LIT_NOISE: begin
            n = $urandom_range(1, 6);
            for (int unsigned i = 0; i < n; i++) begin
               lit_buf.push_back(8'($urandom_range(0, 255)));
            end
         end
         default: begin
            // A well-formed literal with one character replaced by a random byte.
            if ($urandom_range(0, 1) == 1) begin
               lit_buf.push_back(rlti_pkg::CH_DOLLAR);
               add_digits(16, digit_count() + 1);
            end else begin
               add_digits(10, digit_count() + 1);
            end
            lit_buf[$urandom_range(0, lit_buf.size() - 1)] = 8'($urandom_range(0, 255));
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Sender. It offers the next pending character at the falling edge and
   // holds it until the transfer; between characters it idles for a random
   // number of cycles, or not at all during a burst. A character flagged to
   // drain is held back until every converted literal has been returned.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : drive_chars
      char_item_type it;
      logic          hold_now;
      hold_now = 1'b0;
      if (reset) begin
         req_valid     <= 1'b0;
         req_char_code <= 8'h00;
         req_is_last   <= 1'b0;
         tx_gap        <= 0;
      end else if (req_valid && !req_taken) begin
         // The current character has not been transferred yet; keep it steady.
      end else if (tx_gap != 0) begin
         req_valid <= 1'b0;
         tx_gap    <= tx_gap - 1;
      end else if (char_stream.size() != 0 &&
                   !(char_stream[0].drain && converted_literals.size() != 0)) begin
         it = char_stream.pop_front();
         req_valid     <= 1'b1;
         req_char_code <= it.code;
         req_is_last   <= it.last;
         hold_now       = it.hold_rx;
         tx_gap        <= draw_gap(tx_burst);
         tx_loaded     <= tx_loaded + 1;
         if (tx_loaded % 32 == 31) begin
            tx_burst <= ($urandom_range(0, 3) == 0);
         end
      end else begin
         req_valid <= 1'b0;
      end
      rx_hold_req <= hold_now;
   end

   // ------------------------------------------------------------------------
   // Receiver. Before each result it stalls for a random number of cycles,
   // or not at all during a burst. On request from the sender it holds off
   // for a long stretch so that results back up and the block stops taking
   // characters.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : drive_ready
      int unsigned w;
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_wait   <= 0;
         rx_hold   <= 0;
      end else if (rx_hold_req) begin
         rsp_ready <= 1'b0;
         rx_hold   <= HOLD_CYCLES;
      end else if (rx_hold != 0) begin
         rsp_ready <= (rx_hold == 1);
         rx_hold   <= rx_hold - 1;
      end else if (rsp_taken) begin
         w = draw_gap(rx_burst);
         rx_wait   <= w;
         rsp_ready <= (w == 0);
         rx_count  <= rx_count + 1;
         if (rx_count % 16 == 15) begin
            rx_burst <= ($urandom_range(0, 3) == 0);
         end
      end else if (rx_wait != 0) begin
         rsp_ready <= (rx_wait == 1);
         rx_wait   <= rx_wait - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Monitor. At each rising edge it records both handshakes, runs every
   // transferred character through the converter, and compares every
   // transferred result with the oldest converted literal. A watchdog ends
   // the run when nothing moves on either channel for too long.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : watch_ports
      literal_result_type want;
      if (reset) begin
         req_taken   <= 1'b0;
         rsp_taken   <= 1'b0;
         idle_cycles <= 0;
         clear_literal();
      end else begin
         req_taken <= req_valid && req_ready;
         rsp_taken <= rsp_valid && rsp_ready;
         if (req_valid && req_ready) begin
            convert_char(req_char_code, req_is_last);
         end
         if (rsp_valid && rsp_ready) begin
            if (converted_literals.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual value %h ok %b",
                        $time, rsp_value, rsp_ok);
               error_count++;
            end else begin
               want = converted_literals.pop_front();
               if (rsp_value !== want.value) begin
                  $display("%0t: value mismatch, expected %h, actual %h",
                           $time, want.value, rsp_value);
                  error_count++;
               end
               if (rsp_ok !== want.ok) begin
                  $display("%0t: ok mismatch, expected %b, actual %b",
                           $time, want.ok, rsp_ok);
                  error_count++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("tb: failure");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence: a directed set of literals, then random literals with a
   // backed-up stretch and periodic drains, then the end-of-run check.
   // ------------------------------------------------------------------------
   initial begin : run_test
      int unsigned lit_index;
      // Empty digit runs after each prefix and as bare suffix letters.
      queue_text("$");
      queue_text("0x");
      queue_text("0O");
      queue_text("h");
      queue_text("b");
      queue_text("o");
      // A lone zero is decimal with no prefix.
      queue_text("0");
      // After a prefix, a final 'b' is a hex digit rather than a binary suffix.
      queue_text("0Xb");
      queue_text("101b");
      queue_text("7o");
      // A letter digit in a decimal literal makes it invalid.
      queue_text("12a");
      queue_text("9");
      // Extreme character codes, both invalid as digits.
      push_char(8'h00, 1'b1, 1'b0, 1'b0);
      push_char(8'hFF, 1'b1, 1'b0, 1'b0);

      lit_index = 0;
      while (char_stream.size() < RANDOM_CHARS) begin
         if (lit_index == 20) begin
            // Many one-character literals while the receiver holds off, so the
            // result path fills and the block stops accepting characters.
            for (int i = 0; i < 40; i++) begin
               lit_buf.push_back(digit_char(10));
               flush_literal(i == 0, i == 0);
            end
         end
         build_random_literal();
         flush_literal(lit_index % 25 == 24, 1'b0);
         lit_index++;
      end

      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for the last character to go out and its result to come back.
      while (char_stream.size() != 0 || req_valid || converted_literals.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
